[src/rllc_pkg.sv]
// ----------------------------------------------------------------------------
// Run-length line compressor package
// Shared widths, constants and the result entry type.
// ----------------------------------------------------------------------------
package rllc_pkg;

   localparam int DEFAULT_MAX_LINE = 32768;
   localparam int LEN_W            = 16;
   localparam int CNT_W            = 17;
   localparam int RUN_W            = 9;
   localparam int BUF_DEPTH        = 4;
   localparam int BUF_IDX_W        = 2;
   localparam int BUF_CNT_W        = 3;

   localparam logic [RUN_W-1:0] RUN_BIAS = RUN_W'(2);
   localparam logic [RUN_W-1:0] RUN_CAP  = RUN_W'(8'hff) + RUN_BIAS;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             has_byte;
      logic             run_last;
      logic             line_done;
      logic [LEN_W-1:0] byte_count;
   } result_type;

endpackage

[src/run_length_line_compressor.sv]
// ----------------------------------------------------------------------------
// Run-length line compressor
// Compresses raster lines byte by byte into literals and repeat counts.
// ----------------------------------------------------------------------------
// Bytes of a line arrive on the req_ channel, one per transaction, with
// req_tlast on the final byte of the line. Compressed bytes and the line-end
// report leave on the rsp_ channel; the report has rsp_tlast set and carries
// the compressed length. csr_wen writes the line length, clamped to MAX_LINE.
// An accepted byte is compressed in the cycle of acceptance and its results
// are loaded into a four-entry output queue; the first result is visible in the
// next cycle. Each input byte causes zero to four results, which leave one
// per cycle while the receiver is ready, through the output queue's single
// read port. A new byte is taken while the last queued result is being
// delivered.
// When the receiver stalls, the queue holds and req_tready stays low while
// any result is waiting. Reset empties the queue, sets the line length
// to its default and opens a fresh line.
// ----------------------------------------------------------------------------
module run_length_line_compressor #(
   parameter int MAX_LINE = rllc_pkg::DEFAULT_MAX_LINE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // data_byte
   input  logic                     req_tlast,   // line_last
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // out_byte, byte_count
   output logic [1:0]               rsp_tuser,   // has_byte, run_last
   output logic                     rsp_tlast,   // line_done
   input  logic                     csr_wen,
   input  logic [rllc_pkg::LEN_W-1:0] csr_wdata  // line_length
);
   import rllc_pkg::*;

   localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_LINE);
   localparam logic [LEN_W-1:0] RESET_LEN =
      LEN_W'((DEFAULT_MAX_LINE > MAX_LINE) ? MAX_LINE : DEFAULT_MAX_LINE);

   logic [LEN_W-1:0]     line_length_ff;
   logic [7:0]           held_byte_ff,  held_byte_in;
   logic [RUN_W-1:0]     run_count_ff,  run_count_in;
   logic [CNT_W-1:0]     emitted_ff,    emitted_in;
   logic                 line_start_ff, line_start_in;
   logic [LEN_W-1:0]     bytes_in_ff,   bytes_in_in;
   result_type           res_buf_ff [BUF_DEPTH];
   result_type           res_buf_in [BUF_DEPTH];
   logic [BUF_CNT_W-1:0] res_cnt_ff,    res_cnt_in;
   logic                 req_accept;
   logic                 rsp_take;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = (res_cnt_ff == '0) ||
                       ((res_cnt_ff == BUF_CNT_W'(1)) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = (res_cnt_ff != '0);
   assign rsp_tdata  = {res_buf_ff[0].byte_count, res_buf_ff[0].out_byte};
   assign rsp_tuser  = {res_buf_ff[0].run_last, res_buf_ff[0].has_byte};
   assign rsp_tlast  = res_buf_ff[0].line_done;

   always_comb begin
      logic [CNT_W-1:0]     len;
      logic [BUF_CNT_W-1:0] k;
      logic [LEN_W-1:0]     cnt;

      len           = {1'b0, line_length_ff};
      k             = '0;
      cnt           = '0;
      held_byte_in  = held_byte_ff;
      run_count_in  = run_count_ff;
      emitted_in    = emitted_ff;
      line_start_in = line_start_ff;
      bytes_in_in   = bytes_in_ff;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         res_buf_in[i] = '0;
      end

      if (({1'b0, bytes_in_ff} < len) && (emitted_ff < len)) begin
         bytes_in_in = bytes_in_ff + LEN_W'(1);
         if (!line_start_ff && (req_tdata == held_byte_ff)) begin
            if (run_count_ff < RUN_CAP) begin
               run_count_in = run_count_ff + RUN_W'(1);
            end else begin
               res_buf_in[0].out_byte = held_byte_ff;
               res_buf_in[0].has_byte = 1'b1;
               res_buf_in[1].out_byte = 8'(run_count_ff - RUN_BIAS);
               res_buf_in[1].has_byte = 1'b1;
               res_buf_in[2].out_byte = req_tdata;
               res_buf_in[2].has_byte = 1'b1;
               k            = BUF_CNT_W'(3);
               run_count_in = RUN_W'(1);
               emitted_in   = emitted_ff + CNT_W'(3);
            end
         end else begin
            if (run_count_ff > RUN_W'(1)) begin
               res_buf_in[0].out_byte = held_byte_ff;
               res_buf_in[0].has_byte = 1'b1;
               res_buf_in[1].out_byte = 8'(run_count_ff - RUN_BIAS);
               res_buf_in[1].has_byte = 1'b1;
               k          = BUF_CNT_W'(2);
               emitted_in = emitted_ff + CNT_W'(2);
            end
            res_buf_in[k[BUF_IDX_W-1:0]].out_byte = req_tdata;
            res_buf_in[k[BUF_IDX_W-1:0]].has_byte = 1'b1;
            k             = k + BUF_CNT_W'(1);
            held_byte_in  = req_tdata;
            run_count_in  = RUN_W'(1);
            emitted_in    = emitted_in + CNT_W'(1);
            line_start_in = 1'b0;
         end
      end

      if (req_tlast) begin
         if (run_count_in > RUN_W'(1)) begin
            if ((emitted_in + CNT_W'(2)) < len) begin
               res_buf_in[k[BUF_IDX_W-1:0]].out_byte = held_byte_in;
               res_buf_in[k[BUF_IDX_W-1:0]].has_byte = 1'b1;
               k = k + BUF_CNT_W'(1);
               res_buf_in[k[BUF_IDX_W-1:0]].out_byte = 8'(run_count_in - RUN_BIAS);
               res_buf_in[k[BUF_IDX_W-1:0]].has_byte = 1'b1;
               k          = k + BUF_CNT_W'(1);
               emitted_in = emitted_in + CNT_W'(2);
            end else begin
               emitted_in = len;
            end
         end
         cnt = emitted_in[CNT_W-1] ? {LEN_W{1'b1}} : emitted_in[LEN_W-1:0];
         res_buf_in[k[BUF_IDX_W-1:0]].line_done  = 1'b1;
         res_buf_in[k[BUF_IDX_W-1:0]].byte_count = cnt;
         k             = k + BUF_CNT_W'(1);
         held_byte_in  = '0;
         run_count_in  = '0;
         emitted_in    = '0;
         line_start_in = 1'b1;
         bytes_in_in   = '0;
      end

      if (k != '0) begin
         res_buf_in[k[BUF_IDX_W-1:0] - BUF_IDX_W'(1)].run_last = 1'b1;
      end
      res_cnt_in = k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= RESET_LEN;
         held_byte_ff   <= '0;
         run_count_ff   <= '0;
         emitted_ff     <= '0;
         line_start_ff  <= 1'b1;
         bytes_in_ff    <= '0;
         res_cnt_ff     <= '0;
      end else begin
         if (csr_wen) begin
            line_length_ff <= ({1'b0, csr_wdata} > MAX_LEN) ?
                              MAX_LEN[LEN_W-1:0] : csr_wdata;
         end
         if (req_accept) begin
            held_byte_ff  <= held_byte_in;
            run_count_ff  <= run_count_in;
            emitted_ff    <= emitted_in;
            line_start_ff <= line_start_in;
            bytes_in_ff   <= bytes_in_in;
            res_cnt_ff    <= res_cnt_in;
         end else if (rsp_take) begin
            res_cnt_ff <= res_cnt_ff - BUF_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         res_buf_ff <= res_buf_in;
      end else if (rsp_take) begin
         for (int i = 0; i < BUF_DEPTH - 1; i++) begin
            res_buf_ff[i] <= res_buf_ff[i+1];
         end
      end
   end

endmodule
